@@ hw/rtl/wsdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared constants and the request record passed from the parser to the
// unmasking stage.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // Default depth of the queue between the parser and the output stage.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Protocol codes.
  localparam logic [3:0] OPC_PING   = 4'd9;
  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;

  // Header sizes by length code, and the extra bytes of a mask key.
  localparam logic [3:0] HSIZE_SHORT = 4'd2;
  localparam logic [3:0] HSIZE_MED   = 4'd4;
  localparam logic [3:0] HSIZE_LONG  = 4'd10;
  localparam logic [3:0] HSIZE_KEY   = 4'd4;

  // Extended length byte counts, and the discarded upper bytes of a 64-bit length.
  localparam logic [3:0] EXT_NEED16 = 4'd2;
  localparam logic [3:0] EXT_NEED64 = 4'd8;
  localparam logic [3:0] EXT_SKIP64 = 4'd4;
  localparam logic [3:0] KEY_BYTES  = 4'd4;

  // One classified byte, ready for unmasking.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  key_byte;
    logic        is_payload;
    logic [3:0]  opcode;
    logic        masked;
    logic [31:0] length;
    logic [3:0]  hsize;
    logic        frame_end;
  } wsdf_req_t;

endpackage

@@ hw/rtl/wsdf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Walks the frame header byte by byte, keeps the length, mask key and
// payload position, and classifies each accepted byte into a request.
// ----------------------------------------------------------------------------
module wsdf_front import wsdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output wsdf_req_t  req
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [6:0]  code_r, code_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] key_r, key_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic        mask_r, mask_nxt;

  logic        is_pay;
  logic        fend;
  logic [7:0]  key_byte;
  logic [3:0]  hsize;
  logic [3:0]  cnt_inc;
  logic [31:0] pos_inc;
  logic [3:0]  need;
  logic [31:0] len_ext;

  assign cnt_inc = cnt_r + 4'd1;
  assign pos_inc = pos_r + 32'd1;
  assign need    = (code_r == LEN_CODE16) ? EXT_NEED16 : EXT_NEED64;
  assign len_ext = ((code_r == LEN_CODE16) || (cnt_r >= EXT_SKIP64)) ?
                   {len_r[23:0], data_byte} : len_r;

  // Parser next-state logic for one accepted byte.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    opc_nxt   = opc_r;
    mask_nxt  = mask_r;
    is_pay    = 1'b0;
    fend      = 1'b0;
    key_byte  = 8'd0;
    unique case (phase_r)
      PH_HDR1: begin
        mask_nxt = data_byte[7];
        code_nxt = data_byte[6:0];
        cnt_nxt  = 4'd0;
        if (data_byte[6:0] < LEN_CODE16) begin
          len_nxt = {25'd0, data_byte[6:0]};
          if (data_byte[7]) begin
            phase_nxt = PH_KEY;
          end else if (data_byte[6:0] == 7'd0) begin
            phase_nxt = PH_HDR0;
            fend      = 1'b1;
          end else begin
            pos_nxt   = 32'd0;
            phase_nxt = PH_DATA;
          end
        end else begin
          len_nxt   = 32'd0;
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        len_nxt = len_ext;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= need) begin
          cnt_nxt = 4'd0;
          if (mask_r) begin
            phase_nxt = PH_KEY;
          end else if (len_ext == 32'd0) begin
            phase_nxt = PH_HDR0;
            fend      = 1'b1;
          end else begin
            pos_nxt   = 32'd0;
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], data_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= KEY_BYTES) begin
          cnt_nxt = 4'd0;
          if (len_r == 32'd0) begin
            phase_nxt = PH_HDR0;
            fend      = 1'b1;
          end else begin
            pos_nxt   = 32'd0;
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        is_pay = 1'b1;
        if (mask_r) begin
          case (pos_r[1:0])
            2'd0:    key_byte = key_r[31:24];
            2'd1:    key_byte = key_r[23:16];
            2'd2:    key_byte = key_r[15:8];
            default: key_byte = key_r[7:0];
          endcase
        end
        pos_nxt = pos_inc;
        if (pos_inc >= len_r) begin
          fend      = 1'b1;
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        opc_nxt   = data_byte[3:0];
        mask_nxt  = 1'b0;
        code_nxt  = 7'd0;
        len_nxt   = 32'd0;
        pos_nxt   = 32'd0;
        key_nxt   = 32'd0;
        cnt_nxt   = 4'd0;
        phase_nxt = PH_HDR1;
      end
    endcase
  end

  // Header size as known after this byte.
  always_comb begin
    if (code_nxt == LEN_CODE16) begin
      hsize = HSIZE_MED;
    end else if (code_nxt == LEN_CODE64) begin
      hsize = HSIZE_LONG;
    end else begin
      hsize = HSIZE_SHORT;
    end
    if (mask_nxt) begin
      hsize = hsize + HSIZE_KEY;
    end
  end

  // Request record for the queue.
  always_comb begin
    req.data_byte  = data_byte;
    req.key_byte   = key_byte;
    req.is_payload = is_pay;
    req.opcode     = opc_nxt;
    req.masked     = mask_nxt;
    req.length     = len_nxt;
    req.hsize      = hsize;
    req.frame_end  = fend;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      cnt_r   <= 4'd0;
      code_r  <= 7'd0;
      len_r   <= 32'd0;
      pos_r   <= 32'd0;
      key_r   <= 32'd0;
      opc_r   <= 4'd0;
      mask_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      key_r   <= key_nxt;
      opc_r   <= opc_nxt;
      mask_r  <= mask_nxt;
    end
  end

endmodule

@@ hw/rtl/wsdf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer request queue
// Small first-in first-out buffer that decouples the parser from the
// output stage.
// ----------------------------------------------------------------------------
module wsdf_queue import wsdf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  wsdf_req_t wdata,
  output logic      full,
  input  logic      pop,
  output wsdf_req_t rdata,
  output logic      empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wsdf_req_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/wsdf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Takes requests from the queue, unmasks payload bytes, flags ping frames
// and holds the result in an output register until it is popped.
// ----------------------------------------------------------------------------
module wsdf_back import wsdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  wsdf_req_t   q_rdata,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_is_payload,
  output logic [3:0]  out_frame_opcode,
  output logic        out_is_ping,
  output logic        out_was_masked,
  output logic [31:0] out_frame_length,
  output logic [3:0]  out_header_size,
  output logic        out_frame_end
);

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        pay_r;
  logic [3:0]  opc_r;
  logic        ping_r;
  logic        mask_r;
  logic [31:0] len_r;
  logic [3:0]  hsize_r;
  logic        end_r;
  logic        load;

  // Refill the output register when it is free or being popped.
  assign load  = !q_empty && (!valid_r || out_pop);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  // Unmask and register the result fields.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= q_rdata.data_byte ^ q_rdata.key_byte;
      pay_r   <= q_rdata.is_payload;
      opc_r   <= q_rdata.opcode;
      ping_r  <= (q_rdata.opcode == OPC_PING);
      mask_r  <= q_rdata.masked;
      len_r   <= q_rdata.length;
      hsize_r <= q_rdata.hsize;
      end_r   <= q_rdata.frame_end;
    end
  end

  assign out_empty        = !valid_r;
  assign out_byte         = byte_r;
  assign out_is_payload   = pay_r;
  assign out_frame_opcode = opc_r;
  assign out_is_ping      = ping_r;
  assign out_was_masked   = mask_r;
  assign out_frame_length = len_r;
  assign out_header_size  = hsize_r;
  assign out_frame_end    = end_r;

endmodule

@@ hw/rtl/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a byte stream of WebSocket frames and unmasks the payload.
// ----------------------------------------------------------------------------
// Accepts one byte per clock while in_full is low and returns one result per
// byte, in order. A byte is parsed in the cycle it is pushed; its result
// passes through the request queue and then the output register before it
// reaches the out_ ports. Throughput is one byte per clock while in_full is
// low, set by the combinational header parser and the 32-bit payload
// position compare. in_full rises only when QUEUE_DEPTH + 1 results (a full
// queue behind the output register) are held back by a stalled consumer.
// Only the low 32 bits of a 64-bit length are kept, and opcodes are
// reported but not checked.
module websocket_frame_deframer import wsdf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_is_payload,
  output logic [3:0]  out_frame_opcode,
  output logic        out_is_ping,
  output logic        out_was_masked,
  output logic [31:0] out_frame_length,
  output logic [3:0]  out_header_size,
  output logic        out_frame_end
);

  wsdf_req_t front_req;
  wsdf_req_t q_rdata;
  logic      q_full, q_empty, q_pop;
  logic      accept;

  // A request is accepted whenever the queue has room.
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  wsdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .req       (front_req)
  );

  wsdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_req),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  wsdf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_is_payload   (out_is_payload),
    .out_frame_opcode (out_frame_opcode),
    .out_is_ping      (out_is_ping),
    .out_was_masked   (out_was_masked),
    .out_frame_length (out_frame_length),
    .out_header_size  (out_header_size),
    .out_frame_end    (out_frame_end)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds byte streams of WebSocket frames (short, 16-bit and 64-bit lengths,
// masked and unmasked, empty and non-empty) and checks every result against
// a parser model kept in the testbench, under varying push and pop idling.
// ----------------------------------------------------------------------------
module tb;
  import wsdf_pkg::*;

  // Parser phases of the model.
  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA
  } parse_phase_t;

  // One expected result of the deframer.
  typedef struct packed {
    logic [7:0]  data;
    logic        payload;
    logic [3:0]  opcode;
    logic        ping;
    logic        masked;
    logic [31:0] length;
    logic [3:0]  hsize;
    logic        frame_end;
  } deframed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_pop = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [7:0]  out_byte;
  logic        out_is_payload;
  logic [3:0]  out_frame_opcode;
  logic        out_is_ping;
  logic        out_was_masked;
  logic [31:0] out_frame_length;
  logic [3:0]  out_header_size;
  logic        out_frame_end;

  // Stimulus bytes and the results expected back, oldest first.
  logic [7:0]  byte_stream[$];
  deframed_t   deframed_q[$];
  deframed_t   predicted;

  // Parser state of the model.
  parse_phase_t ps = PH_HDR0;
  logic [3:0]  hdr_cnt = 4'd0;
  logic [6:0]  len_code = 7'd0;
  logic [31:0] pay_len = 32'd0;
  logic [31:0] pay_pos = 32'd0;
  logic [31:0] mask_key = 32'd0;
  logic [3:0]  cur_opc = 4'd0;
  logic        mask_on = 1'b0;

  // Run statistics.
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_payload = 0;
  int n_frame_ends = 0;
  int n_pings = 0;
  int n_full_cycles = 0;
  int n_holds = 0;

  // Receiver hold-off for back pressure.
  int hold_cnt = 0;
  int next_hold = 150;

  // Idling pattern steps with the number of accepted bytes.
  logic [1:0]  idle_mode;
  int unsigned send_pct;
  int unsigned recv_pct;
  assign idle_mode = 2'((n_accepted / 120) % 4);
  assign send_pct  = (idle_mode == 2'd1) ? 76 : (idle_mode == 2'd3) ? 28 : 0;
  assign recv_pct  = (idle_mode == 2'd2) ? 76 : (idle_mode == 2'd3) ? 28 : 0;

  websocket_frame_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_is_payload   (out_is_payload),
    .out_frame_opcode (out_frame_opcode),
    .out_is_ping      (out_is_ping),
    .out_was_masked   (out_was_masked),
    .out_frame_length (out_frame_length),
    .out_header_size  (out_header_size),
    .out_frame_end    (out_frame_end)
  );

  always #1 clk = ~clk;

  // Header complete, key included: start the payload or close an empty frame.
  function bit start_payload();
    if (pay_len == 32'd0) begin
      ps = PH_HDR0;
      return 1'b1;
    end
    pay_pos = 32'd0;
    ps = PH_DATA;
    return 1'b0;
  endfunction

  // Length known: collect the key when masked, else go on to the payload.
  function bit finish_length();
    hdr_cnt = 4'd0;
    if (mask_on) begin
      ps = PH_KEY;
      return 1'b0;
    end
    return start_payload();
  endfunction

  // Advances the model by one byte and returns the result it causes.
  task automatic deframe_byte(input logic [7:0] b, output deframed_t r);
    logic [3:0] need;
    logic [3:0] hs;
    r = '0;
    r.data = b;
    case (ps)
      PH_HDR1: begin
        mask_on  = b[7];
        len_code = b[6:0];
        hdr_cnt  = 4'd0;
        if (len_code < LEN_CODE16) begin
          pay_len = {25'd0, len_code};
          r.frame_end = finish_length();
        end else begin
          pay_len = 32'd0;
          ps = PH_EXT;
        end
      end
      PH_EXT: begin
        need = (len_code == LEN_CODE16) ? EXT_NEED16 : EXT_NEED64;
        // The upper four bytes of a 64-bit length are dropped.
        if (len_code == LEN_CODE16 || hdr_cnt >= EXT_SKIP64)
          pay_len = {pay_len[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= need)
          r.frame_end = finish_length();
      end
      PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= KEY_BYTES) begin
          hdr_cnt = 4'd0;
          r.frame_end = start_payload();
        end
      end
      PH_DATA: begin
        // Key byte 0 is the first key byte received, so it sits on top.
        if (mask_on)
          r.data = b ^ mask_key[8 * (3 - pay_pos[1:0]) +: 8];
        r.payload = 1'b1;
        pay_pos = pay_pos + 32'd1;
        if (pay_pos >= pay_len) begin
          r.frame_end = 1'b1;
          ps = PH_HDR0;
        end
      end
      default: begin
        cur_opc  = b[3:0];
        mask_on  = 1'b0;
        len_code = 7'd0;
        pay_len  = 32'd0;
        pay_pos  = 32'd0;
        mask_key = 32'd0;
        hdr_cnt  = 4'd0;
        ps = PH_HDR1;
      end
    endcase
    hs = HSIZE_SHORT;
    if (len_code == LEN_CODE16)
      hs = HSIZE_MED;
    else if (len_code == LEN_CODE64)
      hs = HSIZE_LONG;
    if (mask_on)
      hs = hs + HSIZE_KEY;
    r.opcode = cur_opc;
    r.ping   = (cur_opc == OPC_PING);
    r.masked = mask_on;
    r.length = pay_len;
    r.hsize  = hs;
  endtask

  // Appends one frame to the byte stream. The payload count may be shorter
  // than the declared length, which leaves the frame open.
  task automatic queue_frame(input logic [7:0] hdr0, input bit masked,
                             input logic [6:0] code, input logic [31:0] len,
                             input logic [31:0] upper, input logic [31:0] key,
                             input int unsigned n_pay);
    byte_stream.push_back(hdr0);
    byte_stream.push_back({masked, code});
    if (code == LEN_CODE16) begin
      byte_stream.push_back(len[15:8]);
      byte_stream.push_back(len[7:0]);
    end else if (code == LEN_CODE64) begin
      for (int i = 3; i >= 0; i--) byte_stream.push_back(upper[8 * i +: 8]);
      for (int i = 3; i >= 0; i--) byte_stream.push_back(len[8 * i +: 8]);
    end
    if (masked)
      for (int i = 3; i >= 0; i--) byte_stream.push_back(key[8 * i +: 8]);
    for (int i = 0; i < n_pay; i++) byte_stream.push_back(8'($urandom_range(255)));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Driver: offers the next byte whenever the previous request has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        deframe_byte(in_data_byte, predicted);
        deframed_q.push_back(predicted);
        n_accepted <= n_accepted + 1;
      end
      if (in_push && in_full)
        n_full_cycles <= n_full_cycles + 1;
      if (!in_push || !in_full) begin
        // During a receiver hold-off the sender keeps pushing.
        if (byte_stream.size() != 0 &&
            (hold_cnt != 0 || $urandom_range(99) >= send_pct)) begin
          in_push <= 1'b1;
          in_data_byte <= byte_stream.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter: every 250 accepted bytes from 150 on, the receiver stops popping.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (n_accepted >= next_hold) begin
      hold_cnt <= 60;
      next_hold <= next_hold + 250;
      n_holds <= n_holds + 1;
    end
  end

  // Monitor: compares each popped result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (deframed_q.size() == 0) begin
          n_errors++;
          $display("%0t: result with no request pending, expected none, got byte %h",
                   $time, out_byte);
        end else begin
          predicted = deframed_q.pop_front();
          check_field("out_byte", predicted.data, out_byte);
          check_field("is_payload", predicted.payload, out_is_payload);
          check_field("frame_opcode", predicted.opcode, out_frame_opcode);
          check_field("is_ping", predicted.ping, out_is_ping);
          check_field("was_masked", predicted.masked, out_was_masked);
          check_field("frame_length", predicted.length, out_frame_length);
          check_field("header_size", predicted.hsize, out_header_size);
          check_field("frame_end", predicted.frame_end, out_frame_end);
          n_checked++;
          n_payload += predicted.payload;
          n_frame_ends += predicted.frame_end;
          n_pings += predicted.ping;
        end
      end
      out_pop <= (hold_cnt == 0) && ($urandom_range(99) >= recv_pct);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned sel;
    logic [7:0]  hdr0;
    bit          masked;
    logic [31:0] len;

    // Empty unmasked ping: the frame ends on the second header byte.
    queue_frame({4'h8, OPC_PING}, 1'b0, 7'd0, 32'd0, 32'd0, 32'd0, 0);
    // Reserved opcode with RSV bits set, masked short payload.
    queue_frame(8'h7F, 1'b1, 7'd3, 32'd0, 32'd0, 32'hFF00A55A, 3);
    // 16-bit length, unmasked, one byte passed through unchanged.
    queue_frame(8'h02, 1'b0, LEN_CODE16, 32'd1, 32'd0, 32'd0, 1);
    // 64-bit length with nonzero upper bytes dropped, empty, ends on the key.
    queue_frame(8'h81, 1'b1, LEN_CODE64, 32'd0, 32'hFFFFFFFF, 32'd0, 0);

    // Random well-formed frames of every length form.
    while (byte_stream.size() < 530) begin
      sel = $urandom_range(99);
      hdr0 = 8'($urandom_range(255));
      if ($urandom_range(3) == 0)
        hdr0[3:0] = OPC_PING;
      masked = 1'($urandom_range(1));
      if (sel < 4) begin
        len = $urandom_range(100, 125);
        queue_frame(hdr0, masked, len[6:0], len, 32'd0, $urandom, len);
      end else if (sel < 60) begin
        len = $urandom_range(0, 12);
        queue_frame(hdr0, masked, len[6:0], len, 32'd0, $urandom, len);
      end else if (sel < 78) begin
        len = $urandom_range(0, 16);
        queue_frame(hdr0, masked, LEN_CODE16, len, 32'd0, $urandom, len);
      end else if (sel < 94) begin
        len = $urandom_range(0, 16);
        queue_frame(hdr0, masked, LEN_CODE64, len, $urandom, $urandom, len);
      end else begin
        // Odd but legal: all-zero or all-one keys and oversized encodings.
        len = $urandom_range(0, 6);
        queue_frame(hdr0, 1'b1, LEN_CODE16, len, 32'd0,
                    $urandom_range(1) ? 32'hFFFFFFFF : 32'd0, len);
      end
    end
    // Largest length last, since its payload never finishes.
    queue_frame(8'h82, 1'b1, LEN_CODE64, 32'hFFFFFFFF, $urandom, $urandom, 8);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_stream.size() != 0 || in_push || deframed_q.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    $display("tb: %0d bytes checked, %0d payload bytes, %0d frame ends, %0d ping results",
             n_checked, n_payload, n_frame_ends, n_pings);
    $display("tb: %0d receiver hold-offs, input stalled by full for %0d cycles",
             n_holds, n_full_cycles);
    if (n_errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Watchdog.
  initial begin
    #400000;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/wsdf_pkg.sv
hw/rtl/wsdf_front.sv
hw/rtl/wsdf_queue.sv
hw/rtl/wsdf_back.sv
hw/rtl/websocket_frame_deframer.sv
test/tb.sv
